>>> src/quaternion_arithmetic_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH
`define QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QAU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QAU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/qau_pkg.sv
`timescale 1ns / 1ps
package qau_pkg;

	typedef logic signed [15:0] comp_t;
	typedef logic [3:0] func_t;

	typedef struct packed {
		logic signed [15:0] val;
		logic               sat;
	} clip_t;

	localparam func_t FN_ADD   = 4'd0;
	localparam func_t FN_SUB   = 4'd1;
	localparam func_t FN_NEG   = 4'd2;
	localparam func_t FN_MUL   = 4'd3;
	localparam func_t FN_SCALE = 4'd4;
	localparam func_t FN_CONJ  = 4'd5;
	localparam func_t FN_NORM  = 4'd6;
	localparam func_t FN_MOD   = 4'd7;
	localparam func_t FN_INV   = 4'd8;

	// root bits of the 33-bit squared norm; the divider spends one stage on overflow
	localparam int unsigned UNIT_DEPTH = 17;

	// sign pattern of the Hamilton product: bit j set means the a[j] term is subtracted
	localparam logic [3:0] HAM_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

	function automatic clip_t clip16(input logic signed [39:0] v);
		clip_t r;
		r.sat = 1'b0;
		r.val = v[15:0];
		if (v > 40'sd32767) begin
			r.val = 16'sh7fff;
			r.sat = 1'b1;
		end else if (v < -40'sd32768) begin
			r.val = 16'sh8000;
			r.sat = 1'b1;
		end
		return r;
	endfunction

endpackage

>>> src/quaternion_arithmetic_unit.sv
`timescale 1ns / 1ps
// Quaternion arithmetic unit, signed fixed point with FRAC_BITS fraction bits.
// Input channel s_*: s_tuser carries the function code, s_tdata the quaternions
// a and b. Output channel m_*: m_tdata carries the result quaternion, m_tuser
// the saturated and divide-by-zero flags.
// Four component lanes run side by side; each holds its products, its rounding
// and a restoring divider for the inverse. A shared square-root pipeline gives
// the modulus, and the final stage merges lane results and flags.
// An accepted transaction passes the product and sum registers, the 17-stage
// divider and root pipelines and the output register before its result shows
// on m_tvalid. One transaction per cycle while the receiver does not stall.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_tready drops; s_tready is high whenever the output register is empty or
// being taken.
// Reset clears all valid flags; no transaction is in flight afterwards.
module quaternion_arithmetic_unit #(
	parameter int unsigned FRAC_BITS = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
	input  logic [3:0]   s_tuser,   // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // r_w, r_x, r_y, r_z
	output logic [1:0]   m_tuser    // saturated, divide_by_zero
);
	import qau_pkg::*;

	localparam int unsigned L = UNIT_DEPTH - 1;

	logic  adv;
	comp_t a [4];
	comp_t b [4];

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			a[i] = s_tdata[16*i +: 16];
			b[i] = s_tdata[64 + 16*i +: 16];
		end
	end

	// valid flags
	logic v_s1, v_s2;
	logic v_u [UNIT_DEPTH];
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_u         <= '{default: 1'b0};
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_u[0] <= v_s2;
			for (int t = 1; t < UNIT_DEPTH; t++)
				v_u[t] <= v_u[t-1];
			out_valid_q <= v_u[L];
		end
	end

	// lanes
	logic [30:0]        lane_sq  [4];
	logic signed [15:0] lane_res [4];
	logic               lane_sat [4];
	logic [32:0]        sq_sum_s2;

	genvar g;
	generate
		for (g = 0; g < 4; g++) begin : g_lane
			qau_lane #(
				.LANE      (g),
				.FRAC_BITS (FRAC_BITS)
			) u_lane (
				.clk     (clk),
				.adv     (adv),
				.func    (s_tuser),
				.a       (a),
				.b       (b),
				.norm_sq (sq_sum_s2),
				.sq      (lane_sq[g]),
				.res     (lane_res[g]),
				.sat     (lane_sat[g])
			);
		end
	endgenerate

	// squared norm
	func_t func_s1, func_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1   <= s_tuser;
			func_s2   <= func_s1;
			sq_sum_s2 <= 33'(lane_sq[0]) + 33'(lane_sq[1]) + 33'(lane_sq[2])
				+ 33'(lane_sq[3]);
		end
	end

	logic [17:0] root;

	qau_root u_root (
		.clk    (clk),
		.adv    (adv),
		.sq_sum (sq_sum_s2),
		.root   (root)
	);

	logic [33:0] nrm_c;
	clip_t       nrm_cl;

	always_comb begin
		nrm_c  = (34'(sq_sum_s2) + (34'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		nrm_cl = clip16(40'(nrm_c));
	end

	func_t func_u [UNIT_DEPTH];
	clip_t nrm_u  [UNIT_DEPTH];
	logic  dz_u   [UNIT_DEPTH];

	always_ff @(posedge clk) begin
		if (adv) begin
			func_u[0] <= func_s2;
			nrm_u[0]  <= nrm_cl;
			dz_u[0]   <= sq_sum_s2 == '0;
			for (int t = 1; t < UNIT_DEPTH; t++) begin
				func_u[t] <= func_u[t-1];
				nrm_u[t]  <= nrm_u[t-1];
				dz_u[t]   <= dz_u[t-1];
			end
		end
	end

	// merge lanes, norm and modulus
	clip_t rw;
	logic  sat_c, dz_c;

	always_comb begin
		case (func_u[L])
			FN_NORM: rw = nrm_u[L];
			FN_MOD:  rw = clip16(40'(root));
			default: begin
				rw.val = lane_res[0];
				rw.sat = lane_sat[0];
			end
		endcase
		sat_c = rw.sat | lane_sat[1] | lane_sat[2] | lane_sat[3];
		dz_c  = (func_u[L] == FN_INV) && dz_u[L];
	end

	logic [63:0] out_data_q;
	logic [1:0]  out_user_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {lane_res[3], lane_res[2], lane_res[1], rw.val};
			out_user_q <= {dz_c, sat_c};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

>>> src/qau_root.sv
`timescale 1ns / 1ps
module qau_root (
	input  logic        clk,
	input  logic        adv,
	input  logic [32:0] sq_sum,
	output logic [17:0] root
);
	import qau_pkg::*;

	localparam int unsigned RTW = 21;

	logic [RTW-1:0] rem_u  [UNIT_DEPTH];
	logic [16:0]    root_u [UNIT_DEPTH];
	logic [33:0]    rad_u  [UNIT_DEPTH];

	genvar t;
	generate
		for (t = 0; t < UNIT_DEPTH; t++) begin : g_step
			logic [RTW-1:0] rem_in, r2, trial;
			logic [16:0]    root_in;
			logic [33:0]    rad_in;
			logic           ge;

			if (t == 0) begin : g_first
				assign rem_in  = '0;
				assign root_in = '0;
				assign rad_in  = {1'b0, sq_sum};
			end else begin : g_rest
				assign rem_in  = rem_u[t-1];
				assign root_in = root_u[t-1];
				assign rad_in  = rad_u[t-1];
			end

			// bring down the next two radicand bits and try root*4+1
			assign r2    = RTW'({rem_in, rad_in[33:32]});
			assign trial = RTW'({root_in, 2'b01});
			assign ge    = r2 >= trial;

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_u[t]  <= ge ? r2 - trial : r2;
					root_u[t] <= {root_in[15:0], ge};
					rad_u[t]  <= rad_in << 2;
				end
			end
		end
	endgenerate

	// round to nearest: step up when the remainder exceeds the root
	always_comb begin
		if (rem_u[UNIT_DEPTH-1] > RTW'(root_u[UNIT_DEPTH-1]))
			root = 18'(root_u[UNIT_DEPTH-1]) + 18'd1;
		else
			root = 18'(root_u[UNIT_DEPTH-1]);
	end

endmodule

>>> src/qau_lane.sv
`timescale 1ns / 1ps
module qau_lane #(
	parameter int unsigned LANE      = 0,
	parameter int unsigned FRAC_BITS = 12
) (
	input  logic                clk,
	input  logic                adv,
	input  qau_pkg::func_t      func,
	input  qau_pkg::comp_t      a [4],
	input  qau_pkg::comp_t      b [4],
	input  logic [32:0]         norm_sq,
	output logic [30:0]         sq,
	output logic signed [15:0]  res,
	output logic                sat
);
	import qau_pkg::*;

	localparam int unsigned RW = 35 - FRAC_BITS;
	localparam int unsigned DW = (2 * FRAC_BITS + 18 > 51) ? 2 * FRAC_BITS + 18 : 51;
	localparam int unsigned QB = UNIT_DEPTH - 1;
	localparam int unsigned L  = UNIT_DEPTH - 1;

	// stage 1: products and the exact simple forms
	logic signed [31:0] prod [4];
	logic signed [31:0] sq_c;
	logic signed [16:0] simple_c, c_c;

	always_comb begin
		for (int j = 0; j < 4; j++)
			prod[j] = 32'(a[j]) * 32'(b[2'(LANE ^ j)]);
		sq_c = 32'(a[LANE]) * 32'(a[LANE]);
		c_c  = (LANE == 0) ? 17'(a[LANE]) : -17'(a[LANE]);
		case (func)
			FN_ADD:  simple_c = 17'(a[LANE]) + 17'(b[LANE]);
			FN_SUB:  simple_c = 17'(a[LANE]) - 17'(b[LANE]);
			FN_NEG:  simple_c = -17'(a[LANE]);
			FN_CONJ: simple_c = c_c;
			default: simple_c = '0;
		endcase
	end

	logic signed [31:0] prod_s1 [4];
	logic [30:0]        sq_s1;
	logic signed [16:0] simple_s1;
	func_t              func_s1;
	logic               csign_s1;
	logic [15:0]        cmag_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1   <= prod;
			sq_s1     <= sq_c[30:0];
			simple_s1 <= simple_c;
			func_s1   <= func;
			csign_s1  <= c_c[16];
			cmag_s1   <= c_c[16] ? 16'(-c_c) : 16'(c_c);
		end
	end

	assign sq = sq_s1;

	// stage 2: Hamilton row or scale, rounded half up
	logic signed [33:0]   ham, pick;
	logic signed [34:0]   rsum, rshift;

	always_comb begin
		ham = '0;
		for (int j = 0; j < 4; j++)
			ham = HAM_NEG[LANE][j] ? ham - 34'(prod_s1[j]) : ham + 34'(prod_s1[j]);
		pick   = (func_s1 == FN_MUL) ? ham : 34'(prod_s1[LANE]);
		rsum   = 35'(pick) + (35'(1) << (FRAC_BITS - 1));
		rshift = rsum >>> FRAC_BITS;
	end

	logic signed [RW-1:0] rnd_s2;
	logic signed [16:0]   simple_s2;
	func_t                func_s2;
	logic                 csign_s2;
	logic [15:0]          cmag_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			rnd_s2    <= rshift[RW-1:0];
			simple_s2 <= simple_s1;
			func_s2   <= func_s1;
			csign_s2  <= csign_s1;
			cmag_s2   <= cmag_s1;
		end
	end

	// divider: q = num / den = (2*|c|*2^(2*FRAC_BITS) + S) / (2*S), one quotient bit a stage after the overflow stage
	logic [DW-1:0]        num, den;
	logic [DW-1:0]        rem_u   [UNIT_DEPTH];
	logic [DW-1:0]        den_u   [UNIT_DEPTH];
	logic [QB-1:0]        q_u     [UNIT_DEPTH];
	logic                 ovf_u   [UNIT_DEPTH];
	logic                 zero_u  [UNIT_DEPTH];
	logic signed [RW-1:0] rnd_u   [UNIT_DEPTH];
	logic signed [16:0]   simple_u[UNIT_DEPTH];
	func_t                func_u  [UNIT_DEPTH];
	logic                 csign_u [UNIT_DEPTH];

	assign num = (DW'(cmag_s2) << (2 * FRAC_BITS + 1)) + DW'(norm_sq);
	assign den = DW'(norm_sq) << 1;

	genvar t;
	generate
		for (t = 0; t < UNIT_DEPTH; t++) begin : g_div
			if (t == 0) begin : g_first
				always_ff @(posedge clk) begin
					if (adv) begin
						rem_u[0]    <= num;
						den_u[0]    <= den;
						q_u[0]      <= '0;
						ovf_u[0]    <= num >= (den << QB);
						zero_u[0]   <= norm_sq == '0;
						rnd_u[0]    <= rnd_s2;
						simple_u[0] <= simple_s2;
						func_u[0]   <= func_s2;
						csign_u[0]  <= csign_s2;
					end
				end
			end else begin : g_rest
				localparam int unsigned K = QB - t;
				logic [DW-1:0] trial;
				logic          ge;
				assign trial = den_u[t-1] << K;
				assign ge    = rem_u[t-1] >= trial;
				always_ff @(posedge clk) begin
					if (adv) begin
						rem_u[t]    <= ge ? rem_u[t-1] - trial : rem_u[t-1];
						den_u[t]    <= den_u[t-1];
						q_u[t]      <= {q_u[t-1][QB-2:0], ge};
						ovf_u[t]    <= ovf_u[t-1];
						zero_u[t]   <= zero_u[t-1];
						rnd_u[t]    <= rnd_u[t-1];
						simple_u[t] <= simple_u[t-1];
						func_u[t]   <= func_u[t-1];
						csign_u[t]  <= csign_u[t-1];
					end
				end
			end
		end
	endgenerate

	// pick and clip this component
	clip_t              cl;
	logic signed [39:0] qv;

	always_comb begin
		qv = csign_u[L] ? -40'(q_u[L]) : 40'(q_u[L]);
		cl = '0;
		case (func_u[L]) inside
			FN_ADD, FN_SUB, FN_NEG, FN_CONJ: cl = clip16(40'(simple_u[L]));
			FN_MUL, FN_SCALE:                cl = clip16(40'(rnd_u[L]));
			FN_INV: begin
				if (zero_u[L]) begin
					cl = '0;
				end else if (ovf_u[L]) begin
					cl.val = csign_u[L] ? 16'sh8000 : 16'sh7fff;
					cl.sat = 1'b1;
				end else begin
					cl = clip16(qv);
				end
			end
			default: cl = '0;
		endcase
	end

	assign res = cl.val;
	assign sat = cl.sat;

endmodule

>>> src/qau_checker.sv
`timescale 1ns / 1ps
`include "quaternion_arithmetic_unit_defines.svh"
module qau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [1:0]  m_tuser
);

	`QAU_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	`QAU_ASSERT_SAME(a_dz_zero, m_tvalid && m_tuser[1], m_tdata == 64'd0 && !m_tuser[0], "divide by zero result not clean")
	`QAU_ASSERT_SAME(a_ready_empty, !m_tvalid, s_tready, "not ready while output empty")
	`QAU_ASSERT_SAME(a_stall_back, m_tvalid && !m_tready, !s_tready, "accepting while output stalled")

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
